// ===== hw/rtl/sof_pkg.sv =====
// Shared constants, codes and interface types for the segment overlap filter.
// Used by sof_ctrl, sof_datapath and segment_overlap_filter_unit.
// No dependencies.
`default_nettype none

package sof_pkg;

    // Table depth and coordinate width.
    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 16;

    // Derived widths: table index, fill count, coordinate differences, products, sums.
    localparam int IDX_W  = $clog2(MAX_KEPT);
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SEG_W  = 4 * COORD_BITS;

    // Result field widths on the output channel.
    localparam int STATUS_W = 2;
    localparam int BLOCK_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int OUT_W    = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_KEPT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CROSS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             finish;
    } sof_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } sof_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sof_ctrl.sv =====
// Controller for the segment overlap filter: sequences the table scan and
// the output handshake. Depends on sof_pkg.
`default_nettype none

module sof_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire sof_pkg::sof_stat_t stat,
    output sof_pkg::sof_cmd_t      cmd
);
    import sof_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             mvalid_reg, mvalid_next;
    logic             slot_free;
    logic             last_entry;

    // The result register can take a new result when empty or being drained.
    assign slot_free  = !mvalid_reg || m_tready;
    assign last_entry = ({1'b0, scan_reg} == (stat.count - CNT_W'(1)));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    // Next-state and command logic.
    always_comb begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        cmd.load    = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.rd_addr = scan_reg;
        cmd.finish  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                scan_next = '0;
                if (stat.count == '0) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                scan_next = scan_reg + IDX_W'(1);
                if (last_entry) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!stat.busy) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid is set by a finished item and cleared once the transaction completes.
    always_comb begin
        if (cmd.finish) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            scan_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            scan_reg   <= scan_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sof_datapath.sv =====
// Datapath for the segment overlap filter: candidate registers, kept-segment
// memory, the pipelined crossing test and the result registers. Depends on sof_pkg.
`default_nettype none

module sof_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [sof_pkg::SEG_W-1:0] s_seg,
    input  wire logic                      s_new_set,
    input  wire sof_pkg::sof_cmd_t         cmd,
    output sof_pkg::sof_stat_t             stat,
    output logic [sof_pkg::STATUS_W-1:0]   res_status,
    output logic [sof_pkg::BLOCK_W-1:0]    res_block,
    output logic [sof_pkg::COUNT_W-1:0]    res_count
);
    import sof_pkg::*;

    // Candidate segment and its direction vector.
    logic [SEG_W-1:0]         cand_reg;
    logic signed [DIFF_W-1:0] dx12_reg, dy12_reg;
    logic signed [COORD_BITS-1:0] cxs, cys;
    logic [CNT_W-1:0]         count_reg, count_next;

    // Kept-segment memory and its registered read port.
    logic [SEG_W-1:0] mem [MAX_KEPT];
    logic [SEG_W-1:0] rd_data_reg;
    logic             v1_reg;
    logic [IDX_W-1:0] idx1_reg;

    // Pipeline stage registers.
    logic                     v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]         idx2_reg, idx3_reg, idx4_reg;
    logic signed [DIFF_W-1:0] dx34_reg, dy34_reg, dx13_reg, dy13_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [SUM_W-1:0]  d_reg, tn_reg, un_reg;
    logic signed [COORD_BITS-1:0] qxs, qys, qxe, qye;

    // First crossing found during the scan.
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic             hit;
    logic             d_pos, d_neg, t_in, u_in;

    // Result registers.
    logic [STATUS_W-1:0] status_reg;
    logic [BLOCK_W-1:0]  block_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                table_full;

    assign cxs = cand_reg[COORD_BITS-1:0];
    assign cys = cand_reg[2*COORD_BITS-1:COORD_BITS];
    assign qxs = rd_data_reg[COORD_BITS-1:0];
    assign qys = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign qxe = rd_data_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign qye = rd_data_reg[4*COORD_BITS-1:3*COORD_BITS];

    assign table_full = (count_reg >= CNT_W'(MAX_KEPT));

    // Fill count: cleared by a new set, advanced by an append.
    always_comb begin
        count_next = count_reg;
        if (cmd.load && s_new_set) begin
            count_next = '0;
        end else if (cmd.finish && !found_reg && !table_full) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Capture the candidate and its direction on acceptance.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_reg <= s_seg;
            dx12_reg <= {s_seg[COORD_BITS-1], s_seg[COORD_BITS-1:0]}
                      - {s_seg[3*COORD_BITS-1], s_seg[3*COORD_BITS-1:2*COORD_BITS]};
            dy12_reg <= {s_seg[2*COORD_BITS-1], s_seg[2*COORD_BITS-1:COORD_BITS]}
                      - {s_seg[4*COORD_BITS-1], s_seg[4*COORD_BITS-1:3*COORD_BITS]};
        end
    end

    // Memory write on append, registered read during the scan.
    always_ff @(posedge aclk) begin
        if (cmd.finish && !found_reg && !table_full) begin
            mem[count_reg[IDX_W-1:0]] <= cand_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
        idx1_reg <= cmd.rd_addr;
    end

    // Stage 2: differences against the kept segment.
    always_ff @(posedge aclk) begin
        dx34_reg <= {qxs[COORD_BITS-1], qxs} - {qxe[COORD_BITS-1], qxe};
        dy34_reg <= {qys[COORD_BITS-1], qys} - {qye[COORD_BITS-1], qye};
        dx13_reg <= {cxs[COORD_BITS-1], cxs} - {qxs[COORD_BITS-1], qxs};
        dy13_reg <= {cys[COORD_BITS-1], cys} - {qys[COORD_BITS-1], qys};
        idx2_reg <= idx1_reg;
    end

    // Stage 3: the six cross products.
    always_ff @(posedge aclk) begin
        p1_reg   <= dx12_reg * dy34_reg;
        p2_reg   <= dy12_reg * dx34_reg;
        p3_reg   <= dx13_reg * dy34_reg;
        p4_reg   <= dy13_reg * dx34_reg;
        p5_reg   <= dx13_reg * dy12_reg;
        p6_reg   <= dy13_reg * dx12_reg;
        idx3_reg <= idx2_reg;
    end

    // Stage 4: denominator and the two numerators.
    always_ff @(posedge aclk) begin
        d_reg    <= {p1_reg[PROD_W-1], p1_reg} - {p2_reg[PROD_W-1], p2_reg};
        tn_reg   <= {p3_reg[PROD_W-1], p3_reg} - {p4_reg[PROD_W-1], p4_reg};
        un_reg   <= {p5_reg[PROD_W-1], p5_reg} - {p6_reg[PROD_W-1], p6_reg};
        idx4_reg <= idx3_reg;
    end

    // Stage 5: both parameters lie in [0, 1] when each numerator lies between
    // zero and the denominator; a zero denominator never crosses.
    always_comb begin
        d_pos = !d_reg[SUM_W-1] && (d_reg != '0);
        d_neg = d_reg[SUM_W-1];
        t_in  = 1'b0;
        u_in  = 1'b0;
        if (d_pos) begin
            t_in = !tn_reg[SUM_W-1] && (tn_reg <= d_reg);
            u_in = !un_reg[SUM_W-1] && (un_reg <= d_reg);
        end else if (d_neg) begin
            t_in = (tn_reg <= 0) && (tn_reg >= d_reg);
            u_in = (un_reg <= 0) && (un_reg >= d_reg);
        end
        hit = v4_reg && t_in && u_in;
    end

    // Pipeline valid bits and the first-crossing capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.load) begin
                found_reg <= 1'b0;
            end else if (hit && !found_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hit && !found_reg) begin
            found_idx_reg <= idx4_reg;
        end
    end

    // Result registers, written when the item finishes.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_count_reg <= COUNT_W'(count_next);
            if (found_reg) begin
                status_reg <= ST_CROSS;
                block_reg  <= BLOCK_W'(found_idx_reg);
            end else if (table_full) begin
                status_reg <= ST_FULL;
                block_reg  <= '0;
            end else begin
                status_reg <= ST_KEPT;
                block_reg  <= '0;
            end
        end
    end

    assign stat.count = count_reg;
    assign stat.busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign res_status = status_reg;
    assign res_block  = block_reg;
    assign res_count  = out_count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/segment_overlap_filter_unit.sv =====
// Top level of the segment overlap filter: joins the controller and datapath
// to the stream ports. Depends on sof_pkg, sof_ctrl and sof_datapath.
//
// Channel | Direction | Payload
// s_      | in        | tdata: x_start, y_start, x_end, y_end; tuser: new_set
// m_      | out       | tdata: blocking_index, kept_count; tuser: status
//
// A candidate with N kept entries to test (after any new_set clear) goes from acceptance
// to a valid result through a start step, a scan of the N entries, one kept entry read
// per cycle from the single memory read port, a drain of the test pipeline until it is
// seen idle, and a finish step; on an empty table the scan and the drain are skipped.
// Reset (aresetn low, synchronous) empties the kept table and the output.
// s_tready is high only while idle; a result waiting on m_tready holds the current
// candidate in its finish step, so no new candidate is accepted meanwhile.
`default_nettype none

module segment_overlap_filter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48]
    input  wire logic [0:0]  s_tuser,  // new_set[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // blocking_index[5:0], kept_count[12:6], zero[15:13]
    output logic [1:0]       m_tuser   // status[1:0]
);
    import sof_pkg::*;

    sof_cmd_t            cmd;
    sof_stat_t           stat;
    logic [STATUS_W-1:0] res_status;
    logic [BLOCK_W-1:0]  res_block;
    logic [COUNT_W-1:0]  res_count;

    // Scan sequencing and handshakes.
    sof_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table storage and crossing test.
    sof_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_seg      (s_tdata),
        .s_new_set  (s_tuser[0]),
        .cmd        (cmd),
        .stat       (stat),
        .res_status (res_status),
        .res_block  (res_block),
        .res_count  (res_count)
    );

    // Pack the result transaction.
    assign m_tdata = {3'b000, res_count, res_block};
    assign m_tuser = res_status;

endmodule

`default_nettype wire

// ===== tb/segment_overlap_filter_unit_tb.sv =====
// Self-checking testbench for segment_overlap_filter_unit: drives candidate segments on
// the input stream and checks every result against a predictor of the kept table.
// Depends on sof_pkg and segment_overlap_filter_unit.
`timescale 1ns / 100ps

module segment_overlap_filter_unit_tb;
    import sof_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = MAX_KEPT + 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
    } seg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  blk;
        logic [COUNT_W-1:0]  count;
    } filt_result_t;

    // Shapes of random candidates and of random candidate sets.
    typedef enum {SHAPE_HORIZ, SHAPE_VERT, SHAPE_SHORT, SHAPE_WIDE, SHAPE_POINT,
                  SHAPE_TOUCH, SHAPE_REVERSE} seg_shape_t;
    typedef enum {SET_FILL, SET_MIXED, SET_WIDE} set_style_t;

    // Predicts the filter outcome for each accepted candidate and checks the results.
    class kept_table_scoreboard_t;
        seg_t         kept_tab[MAX_KEPT];
        int unsigned  kept_n;
        filt_result_t expected_q[$];
        int unsigned  mismatches;
        int unsigned  checked;
        int unsigned  n_kept;
        int unsigned  n_cross;
        int unsigned  n_full;

        // Exact integer crossing test, endpoints included, parallel never crosses.
        function bit segs_cross(seg_t p, seg_t q);
            longint dx12, dy12, dx34, dy34, dx13, dy13, den, tnum, unum;
            dx12 = longint'(p.xs) - longint'(p.xe);
            dy12 = longint'(p.ys) - longint'(p.ye);
            dx34 = longint'(q.xs) - longint'(q.xe);
            dy34 = longint'(q.ys) - longint'(q.ye);
            dx13 = longint'(p.xs) - longint'(q.xs);
            dy13 = longint'(p.ys) - longint'(q.ys);
            den  = dx12 * dy34 - dy12 * dx34;
            tnum = dx13 * dy34 - dy13 * dx34;
            unum = dx13 * dy12 - dy13 * dx12;
            if (den == 0)
                return 1'b0;
            if (den < 0) begin
                den  = -den;
                tnum = -tnum;
                unum = -unum;
            end
            return (tnum >= 0) && (tnum <= den) && (unum >= 0) && (unum <= den);
        endfunction

        // Apply one accepted candidate to the kept table and queue its outcome.
        function void note_candidate(seg_t cand, bit clear);
            filt_result_t want;
            int unsigned  i;
            bit           hit;
            if (clear)
                kept_n = 0;
            want.status = ST_KEPT;
            want.blk    = '0;
            hit         = 1'b0;
            for (i = 0; i < kept_n && !hit; i++) begin
                if (segs_cross(cand, kept_tab[i])) begin
                    hit         = 1'b1;
                    want.status = ST_CROSS;
                    want.blk    = BLOCK_W'(i);
                end
            end
            if (!hit) begin
                if (kept_n >= MAX_KEPT) begin
                    want.status = ST_FULL;
                end else begin
                    kept_tab[kept_n] = cand;
                    kept_n++;
                end
            end
            want.count = COUNT_W'(kept_n);
            case (want.status)
                ST_KEPT:  n_kept++;
                ST_CROSS: n_cross++;
                default:  n_full++;
            endcase
            expected_q.insert(expected_q.size(), want);
        endfunction

        // Compare one result transaction with the oldest pending outcome.
        function void check_result(filt_result_t got);
            filt_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result status=%0d index=%0d count=%0d",
                             got.status, got.blk, got.count);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got != want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %0d expected status=%0d index=%0d count=%0d, %s",
                             checked, want.status, want.blk, want.count,
                             $sformatf("got status=%0d index=%0d count=%0d",
                                       got.status, got.blk, got.count));
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SEG_W-1:0]      s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    kept_table_scoreboard_t sb;
    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;
    int unsigned           sent_total;
    int unsigned           cycle_cnt;

    segment_overlap_filter_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Run limit in case the block stops answering.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure changes on the falling edge.
    always @(negedge aclk) begin
        if (aresetn)
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Capture every result transaction on the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{status: m_tuser,
                              blk:    m_tdata[BLOCK_W-1:0],
                              count:  m_tdata[BLOCK_W +: COUNT_W]});
    end

    function automatic seg_t make_seg(int xs, int ys, int xe, int ye);
        return '{xs: coord_t'(xs), ys: coord_t'(ys), xe: coord_t'(xe), ye: coord_t'(ye)};
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t near_coord(coord_t base, int unsigned reach);
        return coord_t'(int'(base) + int'($urandom_range(0, 2 * reach)) - int'(reach));
    endfunction

    // Build one random candidate of the given shape.
    function automatic seg_t pick_segment(seg_shape_t shape);
        seg_t   s;
        seg_t   k;
        coord_t cx;
        coord_t cy;
        cx = any_coord();
        cy = any_coord();
        if ((shape == SHAPE_TOUCH || shape == SHAPE_REVERSE) && sb.kept_n == 0)
            shape = SHAPE_SHORT;
        case (shape)
            SHAPE_HORIZ:   s = '{xs: any_coord(), ys: cy, xe: any_coord(), ye: cy};
            SHAPE_VERT:    s = '{xs: cx, ys: any_coord(), xe: cx, ye: any_coord()};
            SHAPE_SHORT:   s = '{xs: cx, ys: cy, xe: near_coord(cx, 3000),
                                 ye: near_coord(cy, 3000)};
            SHAPE_POINT:   s = '{xs: cx, ys: cy, xe: cx, ye: cy};
            SHAPE_TOUCH: begin
                // Start exactly on an endpoint of a kept segment.
                k = sb.kept_tab[$urandom_range(0, sb.kept_n - 1)];
                s = '{xs: k.xe, ys: k.ye, xe: near_coord(k.xe, 5000),
                      ye: near_coord(k.ye, 5000)};
            end
            SHAPE_REVERSE: begin
                // Same line as a kept segment, traversed the other way.
                k = sb.kept_tab[$urandom_range(0, sb.kept_n - 1)];
                s = '{xs: k.xe, ys: k.ye, xe: k.xs, ye: k.ys};
            end
            default:       s = '{xs: cx, ys: cy, xe: any_coord(), ye: any_coord()};
        endcase
        return s;
    endfunction

    // Offer one candidate, wait for its transaction, and record it. Entered on a falling edge.
    task automatic send_candidate(seg_t cand, bit clear);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom};
            s_tuser  = 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {cand.ye, cand.xe, cand.ys, cand.xs};
        s_tuser  = clear;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_candidate(cand, clear);
        sent_total++;
        @(negedge aclk);
    endtask

    // Random candidate sets: table fills with parallel lines, mixed local shapes, wide lines.
    task automatic run_random_sets(int unsigned n_items);
        int unsigned target;
        int unsigned set_len;
        int unsigned j;
        int unsigned roll;
        set_style_t  style;
        seg_shape_t  shape;
        bit          fresh;
        target = sent_total + n_items;
        while (sent_total < target) begin
            style = set_style_t'($urandom_range(0, 2));
            fresh = ($urandom_range(0, 9) != 0);
            case (style)
                SET_FILL:  set_len = $urandom_range(60, 80);
                SET_MIXED: set_len = $urandom_range(5, 40);
                default:   set_len = $urandom_range(3, 15);
            endcase
            for (j = 0; j < set_len && sent_total < target; j++) begin
                roll = $urandom_range(0, 99);
                case (style)
                    SET_FILL:  shape = (roll < 90) ? SHAPE_HORIZ :
                                       (roll < 95) ? SHAPE_VERT : SHAPE_WIDE;
                    SET_MIXED: shape = (roll < 55) ? SHAPE_SHORT :
                                       (roll < 67) ? SHAPE_TOUCH :
                                       (roll < 77) ? SHAPE_REVERSE :
                                       (roll < 85) ? SHAPE_POINT : SHAPE_WIDE;
                    default:   shape = (roll < 85) ? SHAPE_WIDE : SHAPE_POINT;
                endcase
                send_candidate(pick_segment(shape),
                               (j == 0 && fresh) || ($urandom_range(0, 49) == 0));
            end
        end
    endtask

    // Main sequence.
    initial begin
        sb            = new;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 45;
        sent_total    = 0;
        cycle_cnt     = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, parallel and collinear lines, points, touching endpoints.
        send_candidate(make_seg(-32768, 0, 32767, 0), 1'b1);
        send_candidate(make_seg(0, -32768, 0, 32767), 1'b0);
        send_candidate(make_seg(-32768, 5, 32767, 5), 1'b0);
        send_candidate(make_seg(100, 0, -100, 0), 1'b0);
        send_candidate(make_seg(7, 7, 7, 7), 1'b0);
        send_candidate(make_seg(32767, 0, 32767, -100), 1'b0);
        send_candidate(make_seg(32767, 32767, -32768, -32768), 1'b0);
        send_candidate(make_seg(-1, -1, -1, -1), 1'b0);
        send_candidate(make_seg(-32768, 32767, 32767, -32768), 1'b1);
        send_candidate(make_seg(-32768, -32768, 32767, 32767), 1'b0);
        send_candidate(make_seg(0, 0, -1, -1), 1'b0);
        send_candidate(make_seg(32767, -32768, -32768, 32767), 1'b0);
        send_candidate(make_seg(-32768, -32768, -32768, 32767), 1'b1);
        send_candidate(make_seg(-32768, 32767, 32767, 32767), 1'b0);
        send_candidate(make_seg(32767, 32767, 32767, -32768), 1'b0);
        send_candidate(make_seg(32767, -32768, -32768, -32768), 1'b0);
        send_candidate(make_seg(-1, 0, 0, -1), 1'b0);
        send_candidate(make_seg(0, 0, 0, 0), 1'b0);
        send_candidate(make_seg(-100, -100, 100, 100), 1'b0);
        send_candidate(make_seg(-100, 100, 100, -100), 1'b0);

        // Random part over three back-pressure phases.
        run_random_sets(320);
        send_idle_pct = 45;
        recv_idle_pct = 34;
        run_random_sets(320);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_sets(310);
        s_tvalid = 1'b0;

        // Drain outstanding results, then allow for a late stray transaction.
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d candidates over three back-pressure phases; %0d results checked.",
                 sent_total, sb.checked);
        $display("Outcomes: %0d kept, %0d dropped on crossing, %0d dropped on full table.",
                 sb.n_kept, sb.n_cross, sb.n_full);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sof_pkg.sv
hw/rtl/sof_ctrl.sv
hw/rtl/sof_datapath.sv
hw/rtl/segment_overlap_filter_unit.sv
tb/segment_overlap_filter_unit_tb.sv
